// ----- sv/mrf_pkg.sv -----
package mrf_pkg;

   localparam int unsigned ByteW     = 8;
   localparam int unsigned CrcW      = 16;
   localparam int unsigned HdrBytes  = 6;
   localparam int unsigned FrameLen  = 8;
   localparam int unsigned HdrW      = HdrBytes * ByteW;
   localparam int unsigned IdxW      = $clog2(FrameLen);

   localparam logic [CrcW-1:0] CrcPoly = 16'hA001;
   localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;

   localparam logic [IdxW-1:0] IdxCrcLo = IdxW'(HdrBytes);
   localparam logic [IdxW-1:0] IdxCrcHi = IdxW'(FrameLen - 1);

   // one frame byte as it travels to the output register
   typedef struct packed {
      logic [ByteW-1:0] frame_byte;
      logic             last_byte;
   } frame_beat_type;

   // reflected CRC-16, one byte folded in, LSB first
   function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                                input logic [ByteW-1:0] b);
      logic [CrcW-1:0] c;
      logic            lsb;
      c = crc ^ {{(CrcW-ByteW){1'b0}}, b};
      for (int k = 0; k < ByteW; k++) begin
         lsb = c[0];
         c   = c >> 1;
         if (lsb) begin
            c = c ^ CrcPoly;
         end
      end
      return c;
   endfunction

endpackage

// ----- sv/mrf_frame_seq.sv -----
module mrf_frame_seq
   import mrf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic [HdrW-1:0]     hdr,
   input  logic                out_ready,
   output logic                busy,
   output logic                done,
   output frame_beat_type      beat
);

   logic                busy_ff, busy_in;
   logic [IdxW-1:0]     idx_ff, idx_in;
   logic [HdrW-1:0]     hdr_ff, hdr_in;
   logic [CrcW-1:0]     crc_ff, crc_in;
   logic                adv;
   logic                in_hdr;

   assign adv    = busy_ff && out_ready;
   assign in_hdr = (idx_ff < IdxCrcLo);
   assign busy   = busy_ff;
   assign done   = adv && (idx_ff == IdxCrcHi);

   always_comb begin
      if (in_hdr) begin
         beat.frame_byte = hdr_ff[ByteW-1:0];
      end else if (idx_ff == IdxCrcLo) begin
         beat.frame_byte = crc_ff[ByteW-1:0];
      end else begin
         beat.frame_byte = crc_ff[CrcW-1:ByteW];
      end
      beat.last_byte = (idx_ff == IdxCrcHi);
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      hdr_in  = hdr_ff;
      crc_in  = crc_ff;
      if (adv) begin
         idx_in = idx_ff + 1'b1;
         hdr_in = hdr_ff >> ByteW;
         if (in_hdr) begin
            crc_in = crc_byte(crc_ff, hdr_ff[ByteW-1:0]);
         end
         if (idx_ff == IdxCrcHi) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
         hdr_in  = hdr;
         crc_in  = CrcInit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      hdr_ff <= hdr_in;
      crc_ff <= crc_in;
   end

endmodule

// ----- sv/mrf_out_reg.sv -----
module mrf_out_reg
   import mrf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  frame_beat_type  in_beat,
   output logic            in_ready,
   output logic            out_valid,
   input  logic            out_ready,
   output frame_beat_type  out_beat
);

   logic           valid_ff, valid_in;
   frame_beat_type beat_ff, beat_in;
   logic           take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (take) begin
         valid_in = 1'b1;
         beat_in  = in_beat;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

// ----- sv/modbus_rtu_request_framer.sv -----
// Channel   Dir  Bits  Contents
// req_*     in   48    one request: address, function, register, count/value
// rsp_*     out  8+1   one frame byte per transaction, tlast on CRC high byte
//
// The byte-wide result channel moves one frame byte a cycle while
// rsp_tready is high, and the next request is taken on the cycle the
// eighth byte leaves the sequencer, so frames follow each other with no gap.
// CRC is folded in one byte per cycle as header bytes go out, unless rsp_tready stalls.
// Reset (synchronous) empties sequencer and output register.
// A stalled rsp_tready holds the output register and the sequencer in place.
module modbus_rtu_request_framer
   import mrf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] slave_addr, [15:8] func_code, [31:16] reg_addr, [47:32] count_value
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] frame_byte
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);

   logic           seq_busy;
   logic           seq_done;
   logic           seq_load;
   logic           out_room;
   logic [HdrW-1:0] hdr;
   frame_beat_type seq_beat;
   frame_beat_type out_beat;

   // header in transmit order, first byte in the low bits
   assign hdr = {req_tdata[39:32], req_tdata[47:40],
                 req_tdata[23:16], req_tdata[31:24],
                 req_tdata[15:8],  req_tdata[7:0]};

   // new request as soon as the sequencer is free or handing off its last byte
   assign req_tready = !seq_busy || seq_done;
   assign seq_load   = req_tvalid && req_tready;

   mrf_frame_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .load      (seq_load),
      .hdr       (hdr),
      .out_ready (out_room),
      .busy      (seq_busy),
      .done      (seq_done),
      .beat      (seq_beat)
   );

   mrf_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (seq_busy),
      .in_beat   (seq_beat),
      .in_ready  (out_room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_beat  (out_beat)
   );

   assign rsp_tdata = out_beat.frame_byte;
   assign rsp_tlast = out_beat.last_byte;

endmodule

// ----- sv/mrf_checker.sv -----
module mrf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);

   logic req_seen;
   assign req_seen = req_tvalid && req_tready;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   // output register empty after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   // right after a request is taken the framer is busy and takes no other
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_seen |=> !req_tready)
      else $error("request taken twice in a row");

   // busy and stalled: no new request before the output moves
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && !req_tready |=> !req_tready || rsp_tready)
      else $error("request taken while stalled");

endmodule

bind modbus_rtu_request_framer mrf_checker u_mrf_checker (.*);
